### rtl/core/tape_fsk_byte_framer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tape FSK byte framer
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TAPE_FSK_BYTE_FRAMER_ASSERT_SVH
`define TAPE_FSK_BYTE_FRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define TFBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TFBF_ASSERT_NEVER(label, cond, msg) \
  `TFBF_ASSERT(label, !(cond), msg)
`else
`define TFBF_ASSERT(label, prop, msg)
`define TFBF_ASSERT_NEVER(label, cond, msg)
`endif

`endif

### rtl/core/tfbf_pkg.sv
// ----------------------------------------------------------------------------
// tfbf_pkg
// Shared types and constants of the tape FSK byte framer.
// ----------------------------------------------------------------------------
`default_nettype none

package tfbf_pkg;

  localparam int MAX_SYM   = 15;
  localparam int SYM_IDX_W = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [3:0] MAX_DATA_BITS = 4'd8;
  localparam logic [2:0] MAX_STOP_BITS = 3'd4;

  localparam logic [1:0] PARITY_NONE = 2'd0;
  localparam logic [1:0] PARITY_EVEN = 2'd1;
  localparam logic [1:0] PARITY_ODD  = 2'd2;

  localparam logic [1:0] HALF_SHORT = 2'd1;
  localparam logic [1:0] HALF_LONG  = 2'd2;
  localparam logic [3:0] CYC_ONE    = 4'd1;
  localparam logic [3:0] CYC_TWO    = 4'd2;
  localparam int         SLOW_SHIFT = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_BITS   = 3'd0,
    CFG_PARITY_MODE = 3'd1,
    CFG_STOP_COUNT  = 3'd2,
    CFG_EXTRA_STOP  = 3'd3,
    CFG_SLOW_BAUD   = 3'd4,
    CFG_BASE_RATE   = 3'd5
  } cfg_idx_t;

  // One classified byte: line bits of every symbol, frame length and flags.
  typedef struct packed {
    logic [MAX_SYM-1:0]   bits;
    logic [SYM_IDX_W-1:0] len;
    logic                 extra;
    logic                 slow;
    logic                 eob;
  } frame_t;

endpackage

`default_nettype wire

### rtl/core/tfbf_front.sv
// ----------------------------------------------------------------------------
// tfbf_front
// Holds the configuration and turns an accepted byte into a frame descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module tfbf_front import tfbf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_end_of_block,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 q_full,
  output logic                      q_push,
  output frame_t                    q_frame
);

  logic [3:0] data_bits_r;
  logic [1:0] parity_mode_r;
  logic [2:0] stop_count_r;
  logic       extra_stop_r;
  logic       slow_baud_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bits_r   <= MAX_DATA_BITS;
      parity_mode_r <= PARITY_NONE;
      stop_count_r  <= 3'd1;
      extra_stop_r  <= 1'b0;
      slow_baud_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DATA_BITS:   data_bits_r   <= cfg_wdata[3:0];
        CFG_PARITY_MODE: parity_mode_r <= cfg_wdata[1:0];
        CFG_STOP_COUNT:  stop_count_r  <= cfg_wdata[2:0];
        CFG_EXTRA_STOP:  extra_stop_r  <= cfg_wdata[0];
        CFG_SLOW_BAUD:   slow_baud_r   <= cfg_wdata[0];
        // base rate only names the time unit; no output depends on it
        CFG_BASE_RATE:   ;
        default:         ;
      endcase
    end
  end

  logic [3:0] nbits;
  logic [2:0] nstop;
  logic       par_en;
  logic       par_bit;

  always_comb begin
    nbits   = (data_bits_r > MAX_DATA_BITS) ? MAX_DATA_BITS : data_bits_r;
    nstop   = (stop_count_r > MAX_STOP_BITS) ? MAX_STOP_BITS : stop_count_r;
    par_en  = (parity_mode_r == PARITY_EVEN) || (parity_mode_r == PARITY_ODD);
    par_bit = (^in_data_byte) ^ (parity_mode_r == PARITY_ODD);

    // stop bits and the extra wave are all line 1s
    q_frame.bits    = '1;
    q_frame.bits[0] = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nbits) begin
        q_frame.bits[i+1] = in_data_byte[i];
      end
    end
    if (par_en) begin
      q_frame.bits[nbits + 4'd1] = par_bit;
    end

    q_frame.len   = 4'd1 + nbits + {3'b000, par_en} + {1'b0, nstop}
                    + {3'b000, extra_stop_r};
    q_frame.extra = extra_stop_r;
    q_frame.slow  = slow_baud_r;
    q_frame.eob   = in_end_of_block;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

### rtl/core/tfbf_queue.sv
// ----------------------------------------------------------------------------
// tfbf_queue
// Two-entry frame queue between the classifier and the symbol sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tfbf_queue import tfbf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire frame_t push_frame,
  output logic        full,
  input  wire logic   pop,
  output logic        valid,
  output frame_t      head
);

  frame_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  assign full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign valid = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];

endmodule

`default_nettype wire

### rtl/core/tfbf_back.sv
// ----------------------------------------------------------------------------
// tfbf_back
// Walks the head frame one symbol a cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tape_fsk_byte_framer_assert.svh"

module tfbf_back import tfbf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  input  wire frame_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic        out_bit_value,
  output logic [1:0]  out_half_period,
  output logic [3:0]  out_cycle_count,
  output logic        out_last,
  output logic        out_block_end
);

  logic [SYM_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_bit_r;
  logic [1:0]           out_half_r;
  logic [3:0]           out_cyc_r;
  logic                 out_last_r;
  logic                 out_block_end_r;

  logic       load;
  logic       at_last;
  logic       extra_here;
  logic       bit_sel;
  logic [3:0] base_cyc;
  logic [3:0] cyc_sel;

  always_comb begin
    load       = q_valid && (!out_valid_r || out_ready);
    at_last    = (idx_r == q_head.len - 4'd1);
    extra_here = at_last && q_head.extra;
    bit_sel    = extra_here || q_head.bits[idx_r];
    base_cyc   = bit_sel ? CYC_TWO : CYC_ONE;
    if (extra_here) begin
      cyc_sel = CYC_ONE;
    end else if (q_head.slow) begin
      cyc_sel = base_cyc << SLOW_SHIFT;
    end else begin
      cyc_sel = base_cyc;
    end

    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = at_last ? '0 : idx_r + 4'd1;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_bit_r       <= bit_sel;
      out_half_r      <= bit_sel ? HALF_SHORT : HALF_LONG;
      out_cyc_r       <= cyc_sel;
      out_last_r      <= at_last;
      out_block_end_r <= at_last && q_head.eob;
    end
  end

  assign q_pop           = load && at_last;
  assign out_valid       = out_valid_r;
  assign out_bit_value   = out_bit_r;
  assign out_half_period = out_half_r;
  assign out_cycle_count = out_cyc_r;
  assign out_last        = out_last_r;
  assign out_block_end   = out_block_end_r;

  `TFBF_ASSERT(a_idx_in_frame, q_valid |-> (idx_r < q_head.len), "symbol index past frame end")
  `TFBF_ASSERT(a_pop_rewinds, q_pop |=> (idx_r == '0), "index not rewound after frame")
  `TFBF_ASSERT(a_end_on_last, (out_valid_r && out_block_end_r) |-> out_last_r, "block end off last")
  `TFBF_ASSERT_NEVER(a_cyc_nonzero, out_valid_r && (out_cyc_r == '0), "zero cycle symbol")

endmodule

`default_nettype wire

### rtl/core/tape_fsk_byte_framer.sv
// ----------------------------------------------------------------------------
// tape_fsk_byte_framer
// Path: the byte is registered into the queue, then its first symbol into the
//   output register; later symbols follow one per cycle while out_ready is high.
// Throughput: one symbol per cycle while out_ready is high, so a byte takes
//   1 to 15 symbols (start, data, parity, stop, extra wave), set by the front.
// Reset: synchronous, active low; restores register defaults, empties queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_fsk_byte_framer import tfbf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // byte input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_end_of_block,
  // symbol output channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_bit_value,
  output logic [1:0]                out_half_period,
  output logic [3:0]                out_cycle_count,
  output logic                      out_last,
  output logic                      out_block_end,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // Front: latch the config, classify each byte into a full frame descriptor
  // (every line bit laid out, frame length, extra-wave and slow flags).
  frame_t push_frame;
  logic   q_push;
  logic   q_full;

  tfbf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_block (in_end_of_block),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_frame         (push_frame)
  );

  // Queue: two frames deep, so the next byte transfer can land while the
  // sequencer is still emitting the current frame.
  frame_t head;
  logic   q_valid;
  logic   q_pop;

  tfbf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (head)
  );

  // Back: advance one symbol per output transfer; drop the head frame
  // once its last symbol is loaded into the output register.
  tfbf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bit_value   (out_bit_value),
    .out_half_period (out_half_period),
    .out_cycle_count (out_cycle_count),
    .out_last        (out_last),
    .out_block_end   (out_block_end)
  );

endmodule

`default_nettype wire

### tb/tfbf_frame_check_pkg.sv
// ----------------------------------------------------------------------------
// tfbf_frame_check_pkg
// Predicts the FSK symbols of each framed byte and checks the symbol stream.
// ----------------------------------------------------------------------------
package tfbf_frame_check_pkg;
  import tfbf_pkg::*;

  typedef struct packed {
    logic       bit_value;
    logic [1:0] half_period;
    logic [3:0] cycle_count;
    logic       last;
    logic       block_end;
  } fsk_symbol_t;

  class fsk_frame_tracker;
    // register copy, reset values
    logic [3:0]  data_bits   = MAX_DATA_BITS;
    logic [1:0]  parity_mode = PARITY_NONE;
    logic [2:0]  stop_count  = 3'd1;
    logic        extra_wave  = 1'b0;
    logic        slow_baud   = 1'b0;
    logic [15:0] base_rate   = 16'd1200;

    fsk_symbol_t symbols_due[$];
    int unsigned errors = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_DATA_BITS:   data_bits   = value[3:0];
        CFG_PARITY_MODE: parity_mode = value[1:0];
        CFG_STOP_COUNT:  stop_count  = value[2:0];
        CFG_EXTRA_STOP:  extra_wave  = value[0];
        CFG_SLOW_BAUD:   slow_baud   = value[0];
        CFG_BASE_RATE:   base_rate   = value;
        default: ;
      endcase
    endfunction

    function fsk_symbol_t line_bit(logic b);
      fsk_symbol_t s;
      s.bit_value   = b;
      s.half_period = b ? HALF_SHORT : HALF_LONG;
      s.cycle_count = b ? CYC_TWO : CYC_ONE;
      if (slow_baud) begin
        s.cycle_count = s.cycle_count << SLOW_SHIFT;
      end
      s.last      = 1'b0;
      s.block_end = 1'b0;
      return s;
    endfunction

    // Build the whole frame of one transferred byte and queue its symbols.
    function void note_byte(logic [7:0] data_byte, logic end_of_block);
      fsk_symbol_t frame[$];
      fsk_symbol_t wave;
      logic [3:0]  nbits;
      logic [2:0]  nstop;
      logic        par;
      int          i;
      nbits = (data_bits > MAX_DATA_BITS) ? MAX_DATA_BITS : data_bits;
      nstop = (stop_count > MAX_STOP_BITS) ? MAX_STOP_BITS : stop_count;
      par   = ^data_byte;
      frame.push_back(line_bit(1'b0));
      for (i = 0; i < nbits; i++) begin
        frame.push_back(line_bit(data_byte[i]));
      end
      if (parity_mode == PARITY_EVEN) begin
        frame.push_back(line_bit(par));
      end else if (parity_mode == PARITY_ODD) begin
        frame.push_back(line_bit(~par));
      end
      for (i = 0; i < nstop; i++) begin
        frame.push_back(line_bit(1'b1));
      end
      if (extra_wave) begin
        wave.bit_value   = 1'b1;
        wave.half_period = HALF_SHORT;
        wave.cycle_count = CYC_ONE;
        wave.last        = 1'b0;
        wave.block_end   = 1'b0;
        frame.push_back(wave);
      end
      frame[frame.size()-1].last      = 1'b1;
      frame[frame.size()-1].block_end = end_of_block;
      foreach (frame[k]) begin
        symbols_due.push_back(frame[k]);
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_symbol(fsk_symbol_t got);
      fsk_symbol_t want;
      if (symbols_due.size() == 0) begin
        $error("symbol with none outstanding: bit_value %0d half_period %0d cycle_count %0d",
               got.bit_value, got.half_period, got.cycle_count);
        errors++;
        return;
      end
      want = symbols_due.pop_front();
      compare_field("bit_value",   want.bit_value,   got.bit_value);
      compare_field("half_period", want.half_period, got.half_period);
      compare_field("cycle_count", want.cycle_count, got.cycle_count);
      compare_field("last",        want.last,        got.last);
      compare_field("block_end",   want.block_end,   got.block_end);
    endfunction

    function int unsigned outstanding();
      return symbols_due.size();
    endfunction
  endclass

endpackage

### tb/tape_fsk_byte_framer_test.sv
// ----------------------------------------------------------------------------
// tape_fsk_byte_framer_test
// Drives bytes into the framer under many register settings and idle
// patterns, predicts every FSK symbol of each frame and checks the symbol
// stream field by field, in order.
// ----------------------------------------------------------------------------
module tape_fsk_byte_framer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tfbf_pkg::*;
  import tfbf_frame_check_pkg::*;

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_CYCLES  = 300;

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data_byte    = '0;
  logic                 in_end_of_block = 1'b0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic                 out_bit_value;
  logic [1:0]           out_half_period;
  logic [3:0]           out_cycle_count;
  logic                 out_last;
  logic                 out_block_end;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [CFG_W-1:0]     cfg_wdata       = '0;

  // idle controls, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  fsk_frame_tracker frames = new();

  tape_fsk_byte_framer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_block (in_end_of_block),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bit_value   (out_bit_value),
    .out_half_period (out_half_period),
    .out_cycle_count (out_cycle_count),
    .out_last        (out_last),
    .out_block_end   (out_block_end),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: a pending hold-off wins; otherwise stall at the current rate.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every symbol transfer against the oldest predicted symbol.
  always @(posedge clk) begin
    fsk_symbol_t got;
    if (rst_n && out_valid && out_ready) begin
      got.bit_value   = out_bit_value;
      got.half_period = out_half_period;
      got.cycle_count = out_cycle_count;
      got.last        = out_last;
      got.block_end   = out_block_end;
      frames.check_symbol(got);
    end
  end

  // Offer one byte, with random idle cycles ahead of it; return at the
  // edge of its transfer, leaving in_valid high for the caller to reuse.
  task automatic push_byte(logic [7:0] data_byte, logic end_of_block);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= data_byte;
    in_end_of_block <= end_of_block;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames.note_byte(data_byte, end_of_block);
  endtask

  // Drop valid, wait for every predicted symbol to come out, then settle.
  task automatic drain(int unsigned settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Hold cfg_we high; the caller lowers it after the last write.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    frames.set_reg(idx, value);
  endtask

  // Write all registers; upper data bits carry junk that must be ignored,
  // and one write goes to an index past the list.
  task automatic apply_setting(logic [3:0] dbits, logic [1:0] parity, logic [2:0] stops,
                               logic extra, logic slow, logic [15:0] rate);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_write($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_W'($urandom));
    cfg_write(CFG_DATA_BITS,   {junk[15:4], dbits});
    cfg_write(CFG_PARITY_MODE, {junk[13:0], parity});
    cfg_write(CFG_STOP_COUNT,  {junk[12:0], stops});
    cfg_write(CFG_EXTRA_STOP,  {junk[14:0], extra});
    cfg_write(CFG_SLOW_BAUD,   {junk[15:1], slow});
    cfg_write(CFG_BASE_RATE,   rate);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned count;
    int          i;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults (8 data bits, no parity, one stop bit).
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hA5, 1'b0);
    drain(4);

    // Longest frame: 8 data, odd parity, 4 stops, extra wave, slow baud.
    apply_setting(4'd8, PARITY_ODD, 3'd4, 1'b1, 1'b1, 16'hFFFF);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h96, 1'b0);
    drain(4);

    // Shortest frame: no data bits, no parity, no stops: start bit only.
    apply_setting(4'd0, PARITY_NONE, 3'd0, 1'b0, 1'b0, 16'd1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    drain(4);

    // Even parity covers all eight bits even when only three are sent.
    apply_setting(4'd3, PARITY_EVEN, 3'd2, 1'b1, 1'b0, 16'd1200);
    push_byte(8'hF1, 1'b0);
    push_byte(8'h0E, 1'b1);
    drain(4);

    // Saturation: data bits fifteen, parity mode three, stop count seven.
    apply_setting(4'd15, 2'd3, 3'd7, 1'b0, 1'b1, 16'h0000);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h81, 1'b1);
    drain(4);

    // Data bits nine and stop count five, odd parity, extra wave at full rate.
    apply_setting(4'd9, PARITY_ODD, 3'd5, 1'b1, 1'b0, 16'd300);
    push_byte(8'h3C, 1'b0);
    push_byte(8'hC3, 1'b1);
    drain(4);

    // One data bit, even parity, no stop bits.
    apply_setting(4'd1, PARITY_EVEN, 3'd0, 1'b0, 1'b1, 16'd2400);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFE, 1'b1);
    drain(4);

    // Random phases: fresh registers and idle pattern per phase.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      apply_setting(4'($urandom_range(15)), 2'($urandom_range(3)), 3'($urandom_range(7)),
                    1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      // Once, block the receiver while the sender keeps offering bytes,
      // so the framer fills up and stalls its input.
      if (phase == 4) begin
        hold_left = HOLD_CYCLES;
      end
      count = $urandom_range(10, 30);
      for (i = 0; i < count; i++) begin
        push_byte(8'($urandom), ($urandom_range(3) == 0));
      end
      sent  += count;
      phase += 1;
      drain(4);
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain(30);
    if (frames.errors == 0) begin
      $display("** tape_fsk_byte_framer: PASSED **");
    end else begin
      $display("** tape_fsk_byte_framer: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("** tape_fsk_byte_framer: FAILED **");
    $finish;
  end

endmodule
